[design/ldt_pkg.sv]
// Package for the LFSR dissolve tile address generator.
// Holds shared constants, the command type passed from front to back, and the LFSR step.
// No dependencies.
package ldt_pkg;

  localparam int LfsrW   = 10;
  localparam int SeedW   = 9;
  localparam int CountW  = 7;
  localparam int AddrW   = 10;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 10;

  localparam logic [LfsrW-1:0]  TapMask     = 10'h240;
  localparam int                MaxTiles    = 64;
  localparam int                StepBound   = 1024;
  localparam int                QueueDepth  = 2;

  localparam logic [SeedW-1:0]  SeedReset   = 9'd1;
  localparam logic [CountW-1:0] TilesReset  = 7'd7;
  localparam logic [LfsrW-1:0]  LimitReset  = 10'd600;

  localparam int GridColumnsDefault = 30;
  localparam int RowPitchDefault    = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_SEED     = 2'd0,
    CFG_TILES_PER_TICK = 2'd1,
    CFG_CELL_LIMIT     = 2'd2
  } ldt_cfg_idx_e;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_RESTART = 1'b1
  } ldt_op_e;

  typedef struct packed {
    ldt_op_e           op;
    logic [SeedW-1:0]  seed;
    logic [CountW-1:0] count;   // saturated to MaxTiles
    logic [LfsrW-1:0]  limit;   // never zero
  } ldt_cmd_t;

  // Galois LFSR, shift right, taps folded in on a carry out of bit 0
  function automatic logic [LfsrW-1:0] ldt_lfsr_next(input logic [LfsrW-1:0] v);
    logic [LfsrW-1:0] s;
    s = {1'b0, v[LfsrW-1:1]};
    if (v[0]) begin
      s = s ^ TapMask;
    end
    return s;
  endfunction

endpackage

[design/ldt_intf.sv]
// Handshake channel interfaces: command input, tile address output, register write.
// Depends on ldt_pkg.
interface ldt_in_if;
  import ldt_pkg::*;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface ldt_out_if;
  import ldt_pkg::*;
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] map_address;
  logic             done_res;
  logic             last;
  modport source (output valid, output map_address, output done_res, output last, input ready);
  modport sink   (input valid, input map_address, input done_res, input last, output ready);
endinterface

interface ldt_cfg_if;
  import ldt_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/lfsr_dissolve_tile_address_generator.sv]
// Top level of the LFSR dissolve tile address generator.
// Depends on ldt_pkg, ldt_intf, ldt_front, ldt_queue and ldt_back.
//
//  channel   | dir | payload                              | transfer when
//  ----------+-----+--------------------------------------+------------------
//  in_ch_i   | in  | restart                              | valid && ready
//  out_ch_o  | out | map_address, done_res, last          | valid && ready
//  cfg_ch_i  | in  | index (0 seed, 1 tiles, 2 limit), data | valid && ready
//
// A restart, an idle tick or a zero-tile tick is retired in ST_IDLE when popped.
// A live tick is popped in ST_IDLE; then per tile the back end takes 1 to 1024 LFSR
// steps in ST_STEP (set by the single-step LFSR loop), the reciprocal divide in ST_DIV
// and the address sum in ST_ADDR; a full output register holds ST_ADDR per tile.
// Reset (async, active low) restores the register defaults, empties the queue,
// disarms the generator and clears the LFSR. Config writes always complete.
// The two-entry queue keeps taking input, until it fills, while the back end stalls on out_ch_o.
module lfsr_dissolve_tile_address_generator #(
  parameter int GRID_COLUMNS = ldt_pkg::GridColumnsDefault,
  parameter int ROW_PITCH    = ldt_pkg::RowPitchDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ldt_in_if.sink    in_ch_i,
  ldt_cfg_if.sink   cfg_ch_i,
  ldt_out_if.source out_ch_o
);
  import ldt_pkg::*;

  // front -> queue
  logic     push;
  logic     queue_full;
  ldt_cmd_t push_cmd;

  // queue -> back
  logic     head_valid;
  logic     head_pop;
  ldt_cmd_t head_cmd;

  ldt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch_i),
    .cfg_i        (cfg_ch_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  ldt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (queue_full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .head_o  (head_cmd)
  );

  // back end owns the LFSR, armed flag and the output register
  ldt_back #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .ROW_PITCH    (ROW_PITCH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (head_pop),
    .out_o       (out_ch_o)
  );

endmodule

[design/ldt_front.sv]
// Front end: register file and input classification into queue commands.
// Depends on ldt_pkg and ldt_intf.
module ldt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  ldt_in_if.sink            in_i,
  ldt_cfg_if.sink           cfg_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output ldt_pkg::ldt_cmd_t cmd_o
);
  import ldt_pkg::*;

  logic [SeedW-1:0]  seed_q, seed_d;
  logic [CountW-1:0] tiles_q, tiles_d;
  logic [LfsrW-1:0]  limit_q, limit_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    seed_d  = seed_q;
    tiles_d = tiles_q;
    limit_d = limit_q;
    if (cfg_i.valid) begin
      case (ldt_cfg_idx_e'(cfg_i.index))
        CFG_START_SEED:     seed_d  = cfg_i.data[SeedW-1:0];
        CFG_TILES_PER_TICK: tiles_d = cfg_i.data[CountW-1:0];
        CFG_CELL_LIMIT:     limit_d = cfg_i.data[LfsrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= SeedReset;
      tiles_q <= TilesReset;
      limit_q <= LimitReset;
    end else begin
      seed_q  <= seed_d;
      tiles_q <= tiles_d;
      limit_q <= limit_d;
    end
  end

  assign in_i.ready = !queue_full_i;
  assign push_o     = in_i.valid && !queue_full_i;

  always_comb begin
    cmd_o.op    = in_i.restart ? OP_RESTART : OP_TICK;
    cmd_o.seed  = seed_q;
    cmd_o.count = (tiles_q > CountW'(MaxTiles)) ? CountW'(MaxTiles) : tiles_q;
    cmd_o.limit = (limit_q == '0) ? LfsrW'(1) : limit_q;
  end

endmodule

[design/ldt_queue.sv]
// Short command queue between front and back.
// Depends on ldt_pkg.
module ldt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ldt_pkg::ldt_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output ldt_pkg::ldt_cmd_t head_o
);
  import ldt_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  ldt_cmd_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = do_pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[design/ldt_back.sv]
// Back end: LFSR rejection stepping, cell to address mapping, output register.
// Depends on ldt_pkg and ldt_intf.
module ldt_back #(
  parameter int GRID_COLUMNS = ldt_pkg::GridColumnsDefault,
  parameter int ROW_PITCH    = ldt_pkg::RowPitchDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  ldt_pkg::ldt_cmd_t cmd_i,
  output logic              cmd_pop_o,
  ldt_out_if.source         out_o
);
  import ldt_pkg::*;

  // j div GRID_COLUMNS by reciprocal; exact for every 10-bit j with the default GRID_COLUMNS
  localparam int               DivShift = 16;
  localparam int               RecipW   = DivShift + 1;
  localparam int               ProdW    = LfsrW + RecipW;
  localparam logic [RecipW-1:0] Recip   =
    RecipW'(((1 << DivShift) + GRID_COLUMNS - 1) / GRID_COLUMNS);
  localparam int StepW = $clog2(StepBound + 1);
  localparam int SumW  = 2 * LfsrW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_STEP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_ADDR = 4'b1000
  } ldt_state_e;

  ldt_state_e        state_q, state_d;
  logic [LfsrW-1:0]  lfsr_q, lfsr_d;
  logic [SeedW-1:0]  first_q, first_d;
  logic              armed_q, armed_d;
  logic [CountW-1:0] count_q, count_d;
  logic [LfsrW-1:0]  limit_q, limit_d;
  logic [CountW-1:0] tile_q, tile_d;
  logic [StepW-1:0]  steps_q, steps_d;
  logic [LfsrW-1:0]  cell_q, cell_d;
  logic              done_q, done_d;
  logic [LfsrW-1:0]  quot_q, quot_d;
  logic              out_vld_q, out_vld_d;
  logic [AddrW-1:0]  out_addr_q, out_addr_d;
  logic              out_done_q, out_done_d;
  logic              out_last_q, out_last_d;

  logic [LfsrW-1:0]  lfsr_nxt;
  logic [StepW-1:0]  steps_inc;
  logic [CountW-1:0] tile_inc;
  logic [ProdW-1:0]  prod;
  logic [SumW-1:0]   col_prod;
  logic [LfsrW-1:0]  rem;
  logic [SumW-1:0]   addr_full;
  logic              slot_free;
  logic              is_last;

  assign lfsr_nxt  = ldt_lfsr_next(lfsr_q);
  assign steps_inc = steps_q + StepW'(1);
  assign tile_inc  = tile_q + CountW'(1);
  assign prod      = {{RecipW{1'b0}}, cell_q} * {{LfsrW{1'b0}}, Recip};
  assign col_prod  = SumW'(quot_q) * SumW'(GRID_COLUMNS);
  assign rem       = cell_q - col_prod[LfsrW-1:0];
  assign addr_full = SumW'(rem) + SumW'(quot_q) * SumW'(ROW_PITCH);
  assign slot_free = !out_vld_q || out_o.ready;
  assign is_last   = done_q || (tile_inc == count_q);
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  assign out_o.valid       = out_vld_q;
  assign out_o.map_address = out_addr_q;
  assign out_o.done_res    = out_done_q;
  assign out_o.last        = out_last_q;

  always_comb begin
    state_d    = state_q;
    lfsr_d     = lfsr_q;
    first_d    = first_q;
    armed_d    = armed_q;
    count_d    = count_q;
    limit_d    = limit_q;
    tile_d     = tile_q;
    steps_d    = steps_q;
    cell_d     = cell_q;
    done_d     = done_q;
    quot_d     = quot_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_addr_d = out_addr_q;
    out_done_d = out_done_q;
    out_last_d = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_RESTART) begin
            lfsr_d  = {1'b0, cmd_i.seed};
            first_d = cmd_i.seed;
            armed_d = 1'b1;
          end else if (armed_q && (cmd_i.count != '0)) begin
            count_d = cmd_i.count;
            limit_d = cmd_i.limit;
            tile_d  = '0;
            steps_d = '0;
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        lfsr_d  = lfsr_nxt;
        steps_d = steps_inc;
        if ((lfsr_nxt <= limit_q) || (steps_inc == StepW'(StepBound))) begin
          cell_d  = (lfsr_nxt == limit_q) ? '0 : lfsr_nxt;
          done_d  = (lfsr_nxt == {1'b0, first_q});
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        quot_d  = prod[DivShift +: LfsrW];
        state_d = ST_ADDR;
      end
      ST_ADDR: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_addr_d = addr_full[AddrW-1:0];
          out_done_d = done_q;
          out_last_d = is_last;
          tile_d     = tile_inc;
          steps_d    = '0;
          if (done_q) begin
            armed_d = 1'b0;
          end
          state_d = is_last ? ST_IDLE : ST_STEP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      lfsr_q    <= '0;
      first_q   <= '0;
      armed_q   <= 1'b0;
      tile_q    <= '0;
      steps_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lfsr_q    <= lfsr_d;
      first_q   <= first_d;
      armed_q   <= armed_d;
      tile_q    <= tile_d;
      steps_q   <= steps_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q    <= count_d;
    limit_q    <= limit_d;
    cell_q     <= cell_d;
    done_q     <= done_d;
    quot_q     <= quot_d;
    out_addr_q <= out_addr_d;
    out_done_q <= out_done_d;
    out_last_q <= out_last_d;
  end

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_done_q |-> out_last_q)
    else $error("done result without last");

  a_done_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADDR) && slot_free && done_q |=> !armed_q && (state_q == ST_IDLE))
    else $error("block still armed after done result");

  a_tile_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (tile_q < count_q))
    else $error("tile index past tick count");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (steps_q < StepW'(StepBound)))
    else $error("LFSR step count past bound");
`endif

endmodule

[tb/sv/lfsr_dissolve_tile_address_generator_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the LFSR dissolve tile address generator: directed corners, then
// random restart/tick runs under randomized handshake gaps and one long output stall.
// Depends on ldt_pkg, ldt_intf and the lfsr_dissolve_tile_address_generator RTL.
module lfsr_dissolve_tile_address_generator_tb;
  import ldt_pkg::*;

  localparam int GridCols     = GridColumnsDefault;
  localparam int RowPitch     = RowPitchDefault;
  localparam int MaxGap       = 12;
  localparam int SettleCycles = 64;     // margin for trailing restarts and idle ticks to drain
  localparam int StallAfter   = 300;    // tile count at which the sink goes quiet
  localparam int LongStall    = 300;    // cycles the sink holds ready low at that point
  localparam int ReportCap    = 200;    // keep the log bounded if the stream slips
  localparam int RandomRuns   = 5;
  localparam int RunQuota     = 40;     // counted items per random run, ~230 with directed

  typedef struct packed {
    logic [AddrW-1:0] map_address;
    logic             done_res;
    logic             last;
  } tile_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ldt_in_if  in_ch ();
  ldt_cfg_if cfg_ch ();
  ldt_out_if out_ch ();

  lfsr_dissolve_tile_address_generator #(
    .GRID_COLUMNS(GridCols),
    .ROW_PITCH   (RowPitch)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .cfg_ch_i(cfg_ch),
    .out_ch_o(out_ch)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copies plus the generator state.
  // ---------------------------------------------------------------------------
  logic [SeedW-1:0]  seed_reg  = SeedReset;
  logic [CountW-1:0] tiles_reg = TilesReset;
  logic [LfsrW-1:0]  limit_reg = LimitReset;

  logic [LfsrW-1:0] lfsr_q  = '0;
  logic [LfsrW-1:0] first_q = '0;
  bit               armed_q = 1'b0;

  ldt_op_e      cmd_backlog[$];   // commands not yet offered to the block
  tile_result_t tiles_due[$];     // predicted tiles, oldest first

  int unsigned fail_count = 0;

  // One right shift of the Galois register; a carry out of bit 0 folds in the taps.
  function automatic logic [LfsrW-1:0] lfsr_shift(input logic [LfsrW-1:0] v);
    logic [LfsrW-1:0] s;
    s = v >> 1;
    return v[0] ? (s ^ TapMask) : s;
  endfunction

  // Apply one accepted command to the shadow and queue the tiles it must produce.
  task automatic predict_tiles(input logic restart);
    int unsigned  count, lim, k, steps, cell_idx;
    bit           stop;
    tile_result_t r;
    if (restart) begin
      lfsr_q  = LfsrW'(seed_reg);
      first_q = LfsrW'(seed_reg);
      armed_q = 1'b1;
    end else if (armed_q) begin
      count = (tiles_reg > MaxTiles) ? MaxTiles : tiles_reg;
      lim   = (limit_reg == 0) ? 1 : limit_reg;
      stop  = 1'b0;
      for (k = 0; k < count && !stop; k++) begin
        // rejection stepping: skip values above the limit
        steps = 0;
        do begin
          lfsr_q = lfsr_shift(lfsr_q);
          steps++;
        end while (lfsr_q > lim && steps < StepBound);
        cell_idx      = (lfsr_q == lim) ? 0 : lfsr_q;
        r.map_address = AddrW'((cell_idx % GridCols) + RowPitch * (cell_idx / GridCols));
        r.done_res    = (lfsr_q == first_q);
        r.last        = r.done_res || (k + 1 == count);
        tiles_due.push_back(r);
        if (r.done_res) begin
          armed_q = 1'b0;   // full period seen, the tick ends here
          stop    = 1'b1;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      fail_count++;
      if (fail_count <= ReportCap) begin
        $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both handshakes sampled on the rising edge.
  // ---------------------------------------------------------------------------
  logic in_took  = 1'b0;
  logic out_took = 1'b0;

  always @(posedge clk_i) begin
    tile_result_t want;
    in_took  <= rst_ni && in_ch.valid && in_ch.ready;
    out_took <= rst_ni && out_ch.valid && out_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_tiles(in_ch.restart);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (tiles_due.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportCap) begin
            $error("map_address unexpected: no tile pending, actual %0d", out_ch.map_address);
          end
        end else begin
          want = tiles_due.pop_front();
          check_field("map_address", want.map_address, out_ch.map_address);
          check_field("done_res", want.done_res, out_ch.done_res);
          check_field("last", want.last, out_ch.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver: falling edge, random gap before each command, with calm
  // stretches where commands go back to back.
  // ---------------------------------------------------------------------------
  int unsigned send_gap  = 0;
  bit          send_calm = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && !in_took) begin
        // transfer still pending, hold the command steady
      end else if (send_gap != 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.restart <= cmd_backlog.pop_front();
        if ($urandom_range(0, 15) == 0) begin
          send_calm = !send_calm;
        end
        send_gap = send_calm ? 0 : $urandom_range(0, MaxGap);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tile sink: random wait after each transfer. Once, it goes quiet for a long
  // stretch so the queue fills and the command side backs up.
  // ---------------------------------------------------------------------------
  int unsigned recv_gap   = 0;
  int unsigned tiles_seen = 0;
  bit          recv_calm  = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) begin
        tiles_seen++;
        if (tiles_seen == StallAfter) begin
          recv_gap = LongStall;
        end else begin
          if ($urandom_range(0, 15) == 0) begin
            recv_calm = !recv_calm;
          end
          recv_gap = recv_calm ? 0 : $urandom_range(0, MaxGap);
        end
      end
      out_ch.ready <= (recv_gap == 0);
      if (recv_gap != 0) begin
        recv_gap--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes, only while nothing is in flight.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input ldt_cfg_idx_e idx, input logic [CfgDatW-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      CFG_START_SEED:     seed_reg  = value[SeedW-1:0];
      CFG_TILES_PER_TICK: tiles_reg = value[CountW-1:0];
      CFG_CELL_LIMIT:     limit_reg = value[LfsrW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int seed, input int tiles, input int limit);
    write_reg(CFG_START_SEED, CfgDatW'(seed));
    write_reg(CFG_TILES_PER_TICK, CfgDatW'(tiles));
    write_reg(CFG_CELL_LIMIT, CfgDatW'(limit));
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    #1;
  endtask

  // Wait until every command is taken and every predicted tile has come back,
  // then give trailing no-result commands time to retire.
  task automatic drain();
    do begin
      @(posedge clk_i);
      #1;
    end while (cmd_backlog.size() != 0 || in_ch.valid || tiles_due.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
    #1;
  endtask

  task automatic queue_cmds(input ldt_op_e op, input int unsigned n);
    repeat (n) cmd_backlog.push_back(op);
  endtask

  // Mostly well-formed runs: restart, then ticks until the period closes. Noise is
  // stray ticks while disarmed (ignored, not counted) and restarts mid-run.
  task automatic queue_random_run(input int unsigned quota);
    int unsigned counted, per_tick, span, ticks_left, roll, lim;
    bit          live;
    per_tick = (tiles_reg > MaxTiles) ? MaxTiles : tiles_reg;
    lim      = (limit_reg == 0) ? 1 : limit_reg;
    // values 1..limit each come up once per period, so the run closes after
    // limit tiles unless the seed sits above the limit
    span       = (seed_reg > lim) ? 0 : lim;
    counted    = 0;
    ticks_left = 0;
    live       = 1'b0;
    while (counted < quota) begin
      roll = $urandom_range(0, 99);
      if (!live && roll < 5) begin
        cmd_backlog.push_back(OP_TICK);
      end else if (!live || roll < 4) begin
        cmd_backlog.push_back(OP_RESTART);
        live       = 1'b1;
        ticks_left = (span == 0) ? 0 : (span + per_tick - 1) / per_tick;
        counted++;
      end else begin
        cmd_backlog.push_back(OP_TICK);
        counted++;
        if (ticks_left != 0) begin
          ticks_left--;
          if (ticks_left == 0) begin
            live = 1'b0;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned run, lim, seed;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_START_SEED;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    #1;

    // Reset registers: a tick before any restart is ignored, then a short run.
    queue_cmds(OP_TICK, 1);
    queue_cmds(OP_RESTART, 1);
    queue_cmds(OP_TICK, 2);
    drain();

    // Zero seed ends on the first tile; tiles field all ones saturates to 64.
    set_regs(0, 10'h0FF, 1023);
    queue_cmds(OP_RESTART, 1);
    queue_cmds(OP_TICK, 2);
    drain();

    // Top seed (upper data bit dropped), full tiles, widest limit: addresses wrap.
    set_regs(10'h3FF, MaxTiles, 1023);
    queue_cmds(OP_RESTART, 1);
    queue_cmds(OP_TICK, 2);
    drain();

    // Zero tiles per tick: the tick yields nothing.
    set_regs(5, 0, 100);
    queue_cmds(OP_RESTART, 1);
    queue_cmds(OP_TICK, 1);
    drain();

    // Zero limit behaves as one: a full period of stepping, then done on cell 0.
    set_regs(1, 1, 0);
    queue_cmds(OP_RESTART, 1);
    queue_cmds(OP_TICK, 1);
    drain();

    // Seed above the limit never closes the period.
    set_regs(300, 3, 1);
    queue_cmds(OP_RESTART, 1);
    queue_cmds(OP_TICK, 1);
    drain();

    // Restart mid-run, then run to done and tick once more while disarmed.
    set_regs(3, 2, 10);
    queue_cmds(OP_RESTART, 1);
    queue_cmds(OP_TICK, 1);
    queue_cmds(OP_RESTART, 1);
    queue_cmds(OP_TICK, 6);
    drain();

    // Random runs, one register setting each.
    for (run = 0; run < RandomRuns; run++) begin
      case (run % 5)
        0: begin
          lim = $urandom_range(20, 120);
          set_regs($urandom_range(1, lim), $urandom_range(4, 24), lim);
        end
        1: begin
          set_regs($urandom_range(1, 511),
                   ($urandom_range(0, 3) == 0) ? 127 : $urandom_range(32, MaxTiles),
                   $urandom_range(300, 1023));
        end
        2: begin
          set_regs($urandom_range(1, 511), MaxTiles, 1023);
        end
        3: begin
          lim  = $urandom_range(20, 200);
          seed = $urandom_range(lim + 1, 511);
          set_regs(seed, $urandom_range(1, 12), lim);
        end
        default: begin
          set_regs($urandom_range(1, 511), $urandom_range(1, MaxTiles),
                   $urandom_range(20, 1023));
        end
      endcase
      queue_random_run(RunQuota);
      drain();
    end

    if (fail_count == 0 && tiles_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest expected run.
  initial begin
    #1_000_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
design/ldt_pkg.sv
design/ldt_intf.sv
design/ldt_front.sv
design/ldt_queue.sv
design/ldt_back.sv
design/lfsr_dissolve_tile_address_generator.sv
tb/sv/lfsr_dissolve_tile_address_generator_tb.sv
